// File: rtl/lsr_pkg.sv
// Shared constants, operation and state codes, and link types for the speed ramp.
package lsr_pkg;

   localparam int SPEED_W = 16;
   localparam int MS_W    = 16;
   localparam int ACCEL_W = 15;
   localparam int PROD_W  = ACCEL_W + MS_W;    // accel * ms, unsigned
   localparam int QUOT_W  = 21;                // (32767 * 60000) / 1000 < 2**21, ms is capped

   localparam logic [ACCEL_W-1:0] ACCEL_RESET = 15'd3000;
   localparam logic [MS_W-1:0]    TIMER_CAP   = 16'd60000;

   // Divide by 1000: drop three bits, then multiply by ceil(2**35 / 125).
   localparam int              DIV_PRE_SHIFT = 3;
   localparam int              DIV_SHIFT     = 35;
   localparam int              DIV_X_W       = PROD_W - DIV_PRE_SHIFT;
   localparam int              DIV_RECIP_W   = 29;
   localparam logic [28:0]     DIV_RECIP     = 29'd274877907;
   localparam int              DIV_MUL_W     = DIV_X_W + DIV_RECIP_W;

   localparam logic [2:0] FUNC_TICK     = 3'd0;
   localparam logic [2:0] FUNC_STEP     = 3'd1;
   localparam logic [2:0] FUNC_SET_GOAL = 3'd2;
   localparam logic [2:0] FUNC_SET_INIT = 3'd3;
   localparam logic [2:0] FUNC_START    = 3'd4;
   localparam logic [2:0] FUNC_STOP     = 3'd5;
   localparam logic [2:0] FUNC_RESET    = 3'd6;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_INIT     = 2'd1;
   localparam logic [1:0] ST_CHANGING = 2'd2;
   localparam logic [1:0] ST_PARAM    = 2'd3;

   typedef struct packed {
      logic [MS_W-1:0] ms_next;
      logic [MS_W-1:0] ms_cur;
   } ms_link_type;

   typedef struct packed {
      logic [QUOT_W-1:0] quotient;
      logic              accel_zero;
   } scale_type;

endpackage

// File: rtl/lsr_scale.sv
// Acceleration register, registered accel * ms product and divide-by-1000.
module lsr_scale (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_en,
   input  logic [lsr_pkg::ACCEL_W-1:0] csr_write_data,
   input  lsr_pkg::ms_link_type        ms,
   output lsr_pkg::scale_type          scale
);
   import lsr_pkg::*;

   logic [ACCEL_W-1:0]   accel_ff, accel_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [PROD_W-1:0]    prod_keep, prod_step;
   logic [DIV_X_W-1:0]   div_x;
   logic [DIV_MUL_W-1:0] div_mul;

   always_comb begin
      if (reset) begin
         accel_in = ACCEL_RESET;
      end else if (csr_write_en) begin
         accel_in = csr_write_data;
      end else begin
         accel_in = accel_ff;
      end
      // track the product of the next acceleration and the next ms count;
      // the ms count only clears, holds or steps up by one
      prod_keep = PROD_W'(accel_in) * PROD_W'(ms.ms_cur);
      prod_step = prod_keep + PROD_W'(accel_in);
      if (ms.ms_next == '0) begin
         prod_in = '0;
      end else if (ms.ms_next == ms.ms_cur) begin
         prod_in = prod_keep;
      end else begin
         prod_in = prod_step;
      end
   end

   always_ff @(posedge clock) begin
      accel_ff <= accel_in;
      prod_ff  <= prod_in;
   end

   assign div_x   = prod_ff[PROD_W-1:DIV_PRE_SHIFT];
   assign div_mul = DIV_MUL_W'(div_x) * DIV_MUL_W'(DIV_RECIP);

   assign scale.quotient   = div_mul[DIV_SHIFT+QUOT_W-1:DIV_SHIFT];
   assign scale.accel_zero = (accel_ff == '0);

   a_prod_consistent: assert property (@(posedge clock) disable iff (reset)
      prod_ff == PROD_W'(accel_ff) * PROD_W'(ms.ms_cur))
      else $error("product register out of step with accel and ms");

endmodule

// File: rtl/lsr_ctrl.sv
// Ramp controller: operation decode, state machine and speed state.
module lsr_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic [2:0]                         func,
   input  logic signed [lsr_pkg::SPEED_W-1:0] speed_value,
   input  lsr_pkg::scale_type                 scale,
   output lsr_pkg::ms_link_type               ms,
   output logic signed [lsr_pkg::SPEED_W-1:0] speed_next,
   output logic                               done_next
);
   import lsr_pkg::*;

   localparam int V_W = QUOT_W + 2;

   logic [1:0]                state_ff, state_in;
   logic                      ramp_en_ff, ramp_en_in;
   logic                      timer_en_ff, timer_en_in;
   logic [MS_W-1:0]           ms_ff, ms_in;
   logic signed [SPEED_W-1:0] goal_ff, goal_in;
   logic signed [SPEED_W-1:0] start_ff, start_in;
   logic signed [SPEED_W-1:0] cur_ff, cur_in;

   logic                      dir_up;
   logic signed [V_W-1:0]     start_ext, goal_ext, quot_ext, ramp_v;
   logic                      reached;

   // ramp value and goal test for the changing state
   always_comb begin
      dir_up    = (goal_ff >= start_ff);
      start_ext = V_W'(start_ff);
      goal_ext  = V_W'(goal_ff);
      quot_ext  = $signed({2'b00, scale.quotient});
      ramp_v    = dir_up ? (start_ext + quot_ext) : (start_ext - quot_ext);
      if (scale.accel_zero) begin
         reached = 1'b0;
      end else if (dir_up) begin
         reached = (ramp_v >= goal_ext);
      end else begin
         reached = (ramp_v <= goal_ext);
      end
   end

   always_comb begin
      state_in    = state_ff;
      ramp_en_in  = ramp_en_ff;
      timer_en_in = timer_en_ff;
      ms_in       = ms_ff;
      goal_in     = goal_ff;
      start_in    = start_ff;
      cur_in      = cur_ff;
      if (reset) begin
         state_in    = ST_DONE;
         ramp_en_in  = 1'b0;
         timer_en_in = 1'b0;
         ms_in       = '0;
         goal_in     = '0;
         start_in    = '0;
         cur_in      = '0;
      end else if (advance) begin
         case (func)
            FUNC_TICK: begin
               if (!timer_en_ff) begin
                  ms_in = '0;
               end else if (ms_ff < TIMER_CAP) begin
                  ms_in = ms_ff + 1'b1;
               end
            end
            FUNC_STEP: begin
               if (ramp_en_ff) begin
                  case (state_ff)
                     ST_INIT: begin
                        ms_in = '0;
                        if (goal_ff != start_ff) begin
                           timer_en_in = 1'b1;
                           state_in    = ST_CHANGING;
                        end else begin
                           cur_in      = goal_ff;
                           timer_en_in = 1'b0;
                           state_in    = ST_DONE;
                        end
                     end
                     ST_CHANGING: begin
                        if (reached) begin
                           cur_in      = goal_ff;
                           ms_in       = '0;
                           timer_en_in = 1'b0;
                           state_in    = ST_DONE;
                        end else begin
                           cur_in = ramp_v[SPEED_W-1:0];
                        end
                     end
                     ST_PARAM: begin
                        start_in = cur_ff;
                        ms_in    = '0;
                        state_in = ST_INIT;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            FUNC_SET_GOAL: begin
               if (speed_value != goal_ff) begin
                  goal_in = speed_value;
                  if (ramp_en_ff) begin
                     state_in = ST_PARAM;
                  end
               end
            end
            FUNC_SET_INIT: begin
               start_in = speed_value;
               cur_in   = speed_value;
               if (speed_value != start_ff && ramp_en_ff) begin
                  state_in = ST_PARAM;
               end
            end
            FUNC_START: begin
               ramp_en_in = 1'b1;
               state_in   = ST_INIT;
            end
            FUNC_STOP: begin
               ramp_en_in = 1'b0;
            end
            FUNC_RESET: begin
               state_in    = ST_DONE;
               ms_in       = '0;
               timer_en_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      state_ff    <= state_in;
      ramp_en_ff  <= ramp_en_in;
      timer_en_ff <= timer_en_in;
      ms_ff       <= ms_in;
      goal_ff     <= goal_in;
      start_ff    <= start_in;
      cur_ff      <= cur_in;
   end

   assign ms.ms_next = ms_in;
   assign ms.ms_cur  = ms_ff;
   assign speed_next = cur_in;
   assign done_next  = (state_in == ST_DONE);

   a_ms_capped: assert property (@(posedge clock) disable iff (reset)
      ms_ff <= TIMER_CAP)
      else $error("ms count above cap");

   a_timer_not_done: assert property (@(posedge clock) disable iff (reset)
      timer_en_ff |-> state_ff != ST_DONE)
      else $error("timer running in done state");

endmodule

// File: rtl/linear_speed_ramp.sv
// Linear speed ramp generator top level: input register, controller, result register.
// An accepted item is held in the input register, processed once the result register is
//   free or being drained, and its result is then registered for the receiver.
// Throughput: one item per cycle while the receiver takes results; the controller's next
//   state is combinational, and the divide by 1000 works from the registered accel * ms product.
// Reset (synchronous, active high): empty both registers, state to done, speeds and
//   ms count to zero, acceleration to 3000.
module linear_speed_ramp (
   input  logic                               clock,
   input  logic                               reset,
   // input items
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [2:0]                         req_func,
   input  logic signed [lsr_pkg::SPEED_W-1:0] req_speed_value,
   // result items
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [lsr_pkg::SPEED_W-1:0] rsp_process_speed,
   output logic                               rsp_ramp_done,
   // acceleration register
   input  logic                               csr_write_en,
   input  logic [lsr_pkg::ACCEL_W-1:0]        csr_write_data
);
   import lsr_pkg::*;

   logic                      in_valid_ff, in_valid_in;
   logic [2:0]                in_func_ff;
   logic signed [SPEED_W-1:0] in_speed_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SPEED_W-1:0] rsp_speed_ff;
   logic                      rsp_done_ff;

   logic                      advance;
   ms_link_type               ms;
   scale_type                 scale;
   logic signed [SPEED_W-1:0] speed_next;
   logic                      done_next;

   // Process the held item whenever the result register is free or being drained.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   // Take a new item when the input register is empty or empties this cycle.
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      if (reset) begin
         in_valid_in = 1'b0;
      end else if (req_ready) begin
         in_valid_in = req_valid;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (reset) begin
         rsp_valid_in = 1'b0;
      end else if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      in_valid_ff  <= in_valid_in;
      rsp_valid_ff <= rsp_valid_in;
   end

   // Capture the item payload on acceptance; hold it otherwise.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_func_ff  <= req_func;
         in_speed_ff <= req_speed_value;
      end
   end

   // Load the result of the item being processed.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_speed_ff <= speed_next;
         rsp_done_ff  <= done_next;
      end
   end

   lsr_scale u_scale (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .ms             (ms),
      .scale          (scale)
   );

   lsr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .func        (in_func_ff),
      .speed_value (in_speed_ff),
      .scale       (scale),
      .ms          (ms),
      .speed_next  (speed_next),
      .done_next   (done_next)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_process_speed = rsp_speed_ff;
   assign rsp_ramp_done     = rsp_done_ff;

   // A stalled input side means an item is held behind a blocked result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("input stalled without a blocked result");

   // A new result comes only from a held item.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff))
      else $error("result appeared without an item");

endmodule

// File: bench/lsr_ramp_checker.sv
// Result checker for the speed ramp: tracks the ramp state and compares every result item.
module lsr_ramp_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [2:0]                         req_func,
   input  logic signed [lsr_pkg::SPEED_W-1:0] req_speed_value,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic signed [lsr_pkg::SPEED_W-1:0] rsp_process_speed,
   input  logic                               rsp_ramp_done,
   input  logic                               csr_write_en,
   input  logic [lsr_pkg::ACCEL_W-1:0]        csr_write_data,
   output int                                 fail_count,
   output int                                 pending_count,
   output int                                 checked_count
);
   import lsr_pkg::*;

   typedef struct packed {
      logic signed [SPEED_W-1:0] speed;
      logic                      done;
   } ramp_result_type;

   // expected result items, oldest first
   ramp_result_type speed_expected[$];
   ramp_result_type got_want;

   logic [ACCEL_W-1:0]        rate_reg;
   logic [1:0]                ctl_state;
   logic                      ramp_on;
   logic                      timer_on;
   logic [MS_W-1:0]           elapsed_ms;
   logic signed [SPEED_W-1:0] target_speed;
   logic signed [SPEED_W-1:0] base_speed;
   logic signed [SPEED_W-1:0] out_speed;
   int                        fails  = 0;
   int                        checks = 0;

   task automatic settle_on_target();
      out_speed  = target_speed;
      ctl_state  = ST_DONE;
      elapsed_ms = '0;
      timer_on   = 1'b0;
   endtask

   // Advance the tracked ramp by one item and queue the result it causes.
   task automatic predict_speed(input logic [2:0] func, input logic signed [SPEED_W-1:0] value);
      longint          slope;
      longint          ramp_v;
      ramp_result_type entry;
      case (func)
         FUNC_TICK: begin
            if (timer_on) begin
               if (elapsed_ms < TIMER_CAP) elapsed_ms = elapsed_ms + 16'd1;
            end else begin
               elapsed_ms = '0;
            end
         end
         FUNC_STEP: begin
            if (ramp_on) begin
               case (ctl_state)
                  ST_INIT: begin
                     if (target_speed != base_speed) begin
                        elapsed_ms = '0;
                        timer_on   = 1'b1;
                        ctl_state  = ST_CHANGING;
                     end else begin
                        settle_on_target();
                     end
                  end
                  ST_CHANGING: begin
                     slope  = (target_speed >= base_speed) ? longint'(rate_reg)
                                                           : -longint'(rate_reg);
                     ramp_v = slope * longint'(elapsed_ms) / 1000 + longint'(base_speed);
                     if ((slope > 0 && ramp_v >= target_speed) ||
                         (slope < 0 && ramp_v <= target_speed)) begin
                        settle_on_target();
                     end else begin
                        out_speed = ramp_v[SPEED_W-1:0];
                     end
                  end
                  ST_PARAM: begin
                     base_speed = out_speed;
                     elapsed_ms = '0;
                     ctl_state  = ST_INIT;
                  end
                  default: ;
               endcase
            end
         end
         FUNC_SET_GOAL: begin
            if (value != target_speed) begin
               target_speed = value;
               if (ramp_on) ctl_state = ST_PARAM;
            end
         end
         FUNC_SET_INIT: begin
            if (value != base_speed) begin
               base_speed = value;
               if (ramp_on) ctl_state = ST_PARAM;
            end
            out_speed = base_speed;
         end
         FUNC_START: begin
            ramp_on   = 1'b1;
            ctl_state = ST_INIT;
         end
         FUNC_STOP: ramp_on = 1'b0;
         FUNC_RESET: begin
            ctl_state  = ST_DONE;
            elapsed_ms = '0;
            timer_on   = 1'b0;
         end
         default: ;
      endcase
      entry.speed = out_speed;
      entry.done  = (ctl_state == ST_DONE);
      speed_expected.push_back(entry);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rate_reg     = ACCEL_RESET;
         ctl_state    = ST_DONE;
         ramp_on      = 1'b0;
         timer_on     = 1'b0;
         elapsed_ms   = '0;
         target_speed = '0;
         base_speed   = '0;
         out_speed    = '0;
         speed_expected.delete();
      end else begin
         if (csr_write_en) rate_reg = csr_write_data;
         if (req_valid && req_ready) predict_speed(req_func, req_speed_value);
         if (rsp_valid && rsp_ready) begin
            if (speed_expected.size() == 0) begin
               fails++;
               $display("%0t: unexpected result item, actual speed %0d done %0b",
                        $time, rsp_process_speed, rsp_ramp_done);
            end else begin
               got_want = speed_expected.pop_front();
               checks++;
               if (rsp_process_speed !== got_want.speed ||
                   rsp_ramp_done !== got_want.done) begin
                  fails++;
                  if (rsp_process_speed !== got_want.speed)
                     $display("%0t: process_speed expected %0d actual %0d",
                              $time, $signed(got_want.speed), rsp_process_speed);
                  if (rsp_ramp_done !== got_want.done)
                     $display("%0t: ramp_done expected %0b actual %0b",
                              $time, got_want.done, rsp_ramp_done);
               end
            end
         end
      end
      fail_count    <= fails;
      pending_count <= speed_expected.size();
      checked_count <= checks;
   end

endmodule

// File: bench/tb_linear_speed_ramp.sv
// Testbench top for the linear speed ramp: stimulus, receiver stalls, watchdog and verdict.
module tb_linear_speed_ramp;
   import lsr_pkg::*;

   localparam int RANDOM_ITEMS   = 1500;
   localparam int PHASES         = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   // a long stretch of ticks on the slowest ramp
   localparam int LONG_TICKS     = 100;

   localparam logic [2:0]                FUNC_UNUSED = 3'd7;
   localparam logic signed [SPEED_W-1:0] SPEED_MAX   = 16'sh7fff;
   localparam logic signed [SPEED_W-1:0] SPEED_MIN   = 16'sh8000;

   logic                      clock           = 1'b0;
   logic                      reset           = 1'b1;
   logic                      req_valid       = 1'b0;
   logic                      req_ready;
   logic [2:0]                req_func        = FUNC_TICK;
   logic signed [SPEED_W-1:0] req_speed_value = '0;
   logic                      rsp_valid;
   logic                      rsp_ready       = 1'b0;
   logic signed [SPEED_W-1:0] rsp_process_speed;
   logic                      rsp_ramp_done;
   logic                      csr_write_en    = 1'b0;
   logic [ACCEL_W-1:0]        csr_write_data  = ACCEL_RESET;

   int fail_count;
   int pending_count;
   int checked_count;
   int items_sent  = 0;
   int burst_left  = 0;
   int idle_cycles = 0;
   int stall_mode  = 0;
   int mode_left   = 0;
   int rate_writes = 0;

   always #5 clock = ~clock;

   linear_speed_ramp i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_speed_value   (req_speed_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_process_speed (rsp_process_speed),
      .rsp_ramp_done     (rsp_ramp_done),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data)
   );

   lsr_ramp_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_speed_value   (req_speed_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_process_speed (rsp_process_speed),
      .rsp_ramp_done     (rsp_ramp_done),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data),
      .fail_count        (fail_count),
      .pending_count     (pending_count),
      .checked_count     (checked_count)
   );

   // Random speed value over the full signed range.
   function automatic logic signed [SPEED_W-1:0] rand_speed();
      return SPEED_W'($urandom);
   endfunction

   // Receiver: switch at random between stall patterns.
   // Mode 0 never stalls, 1 is a coin toss, 2 stalls most cycles, 3 drops one cycle in four.
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         mode_left  <= $urandom_range(20, 200);
      end else begin
         mode_left  <= mode_left - 1;
      end
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(0, 1) == 1);
         2:       rsp_ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ready <= ((mode_left % 4) != 0);
      endcase
   end

   // Watchdog: count cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired, %0d results still outstanding", $time, pending_count);
         $display("status: fail");
         $finish;
      end
   end

   // Offer one item and hold it until accepted. Between bursts, valid may drop for a
   // random gap; inside a burst, valid stays high and only the payload moves on.
   task automatic send_item(input logic [2:0] func, input logic signed [SPEED_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : $urandom_range(0, 3);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         // mostly short bursts, now and then a long stretch with no gaps
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 40);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_func        <= func;
      req_speed_value <= value;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Drop valid and hold off until every expected result item has come back.
   task automatic go_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      // wait for an edge first so the count includes the item taken at this edge
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write the acceleration register while the block is idle.
   task automatic write_rate(input logic [ACCEL_W-1:0] rate);
      go_idle();
      csr_write_en   <= 1'b1;
      csr_write_data <= rate;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      rate_writes++;
   endtask

   // One well-formed ramp: set start and target, start, then rounds of ticks and a
   // step, with the odd disturbance mixed in. The target usually sits close enough
   // to the start that the ramp finishes within a few dozen ms.
   task automatic drive_ramp_sequence(input logic [ACCEL_W-1:0] rate);
      int                        span;
      int                        goal_i;
      int                        rounds;
      logic signed [SPEED_W-1:0] init_v;
      logic signed [SPEED_W-1:0] goal_v;
      case ($urandom_range(0, 7))
         0:       init_v = SPEED_MIN;
         1:       init_v = SPEED_MAX;
         default: init_v = rand_speed();
      endcase
      span = int'(rate) * $urandom_range(5, 60) / 1000 + $urandom_range(1, 4);
      if ($urandom_range(0, 7) == 0) begin
         goal_v = rand_speed();
      end else begin
         goal_i = int'(init_v) + (($urandom_range(0, 1) == 1) ? span : -span);
         if (goal_i > 32767) goal_i = 32767;
         if (goal_i < -32768) goal_i = -32768;
         goal_v = goal_i[SPEED_W-1:0];
      end
      // starting first sends the speed updates through the parameter change path
      if ($urandom_range(0, 3) == 0) begin
         send_item(FUNC_START, rand_speed());
         send_item(FUNC_SET_INIT, init_v);
         send_item(FUNC_SET_GOAL, goal_v);
      end else begin
         send_item(FUNC_SET_INIT, init_v);
         send_item(FUNC_SET_GOAL, goal_v);
         send_item(FUNC_START, rand_speed());
      end
      rounds = $urandom_range(4, 16);
      repeat (rounds) begin
         repeat ($urandom_range(0, 12)) send_item(FUNC_TICK, rand_speed());
         send_item(FUNC_STEP, rand_speed());
         if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 7))
               0:       send_item(FUNC_SET_GOAL, goal_v ^ SPEED_W'($urandom_range(0, 7)));
               1:       send_item(FUNC_SET_INIT, init_v ^ SPEED_W'($urandom_range(0, 7)));
               2:       send_item(FUNC_STOP, rand_speed());
               3:       send_item(FUNC_START, rand_speed());
               4:       send_item(FUNC_RESET, rand_speed());
               5:       send_item(FUNC_UNUSED, rand_speed());
               6:       send_item(FUNC_SET_GOAL, goal_v);
               default: send_item(FUNC_STEP, rand_speed());
            endcase
         end
      end
   endtask

   initial begin : stimulus
      int                 random_base;
      logic [ACCEL_W-1:0] phase_rate;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part, acceleration at its reset value of 3000.
      send_item(FUNC_STEP, rand_speed());       // step while disabled and done
      send_item(FUNC_UNUSED, SPEED_MAX);        // unused code reports the state
      send_item(FUNC_SET_GOAL, SPEED_MAX);
      send_item(FUNC_SET_INIT, SPEED_MIN);      // current follows the new start
      send_item(FUNC_START, rand_speed());
      send_item(FUNC_STEP, rand_speed());       // init -> changing
      repeat (3) send_item(FUNC_TICK, rand_speed());
      send_item(FUNC_STEP, rand_speed());       // rising ramp, 3 ms
      send_item(FUNC_SET_GOAL, SPEED_MIN);      // new target while enabled
      send_item(FUNC_STEP, rand_speed());       // parameter change -> init
      send_item(FUNC_STEP, rand_speed());       // init -> changing, falling
      repeat (2) send_item(FUNC_TICK, rand_speed());
      send_item(FUNC_STEP, rand_speed());
      repeat (3) send_item(FUNC_TICK, rand_speed());
      send_item(FUNC_STEP, rand_speed());       // passes the target, clamp and finish
      send_item(FUNC_SET_GOAL, SPEED_MIN);      // same target, no restart
      send_item(FUNC_STOP, rand_speed());
      send_item(FUNC_SET_GOAL, 16'sd100);       // disabled, no restart
      send_item(FUNC_STEP, rand_speed());       // step while disabled
      send_item(FUNC_START, rand_speed());
      send_item(FUNC_STEP, rand_speed());
      send_item(FUNC_TICK, rand_speed());
      send_item(FUNC_RESET, rand_speed());      // back to done, timer off
      send_item(FUNC_TICK, rand_speed());       // timer off clears the count
      send_item(FUNC_SET_INIT, 16'sd100);       // start equals target
      send_item(FUNC_START, rand_speed());
      send_item(FUNC_STEP, rand_speed());       // init finishes at once

      // Zero acceleration: the ramp holds its start and never finishes.
      write_rate('0);
      send_item(FUNC_SET_INIT, 16'sd0);
      send_item(FUNC_SET_GOAL, -16'sd5);
      send_item(FUNC_START, rand_speed());
      send_item(FUNC_STEP, rand_speed());
      repeat (10) send_item(FUNC_TICK, rand_speed());
      send_item(FUNC_STEP, rand_speed());

      // Slowest ramp over the full range: a long run of ticks barely moves it.
      write_rate(15'd1);
      send_item(FUNC_SET_INIT, SPEED_MIN);
      send_item(FUNC_SET_GOAL, SPEED_MAX);
      send_item(FUNC_START, rand_speed());
      send_item(FUNC_STEP, rand_speed());
      repeat (LONG_TICKS) send_item(FUNC_TICK, rand_speed());
      send_item(FUNC_STEP, rand_speed());
      send_item(FUNC_RESET, rand_speed());

      // Random part: one acceleration setting per phase, extremes among them.
      random_base = items_sent;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       phase_rate = 15'd32767;
            1:       phase_rate = 15'd1;
            3:       phase_rate = ACCEL_RESET;
            5:       phase_rate = '0;
            7:       phase_rate = 15'd32767;
            default: phase_rate = ACCEL_W'($urandom_range(2, 32766));
         endcase
         write_rate(phase_rate);
         while (items_sent - random_base < (phase + 1) * RANDOM_ITEMS / PHASES) begin
            if ($urandom_range(0, 6) == 0) begin
               repeat ($urandom_range(1, 5)) send_item(3'($urandom_range(0, 7)), rand_speed());
            end else begin
               drive_ramp_sequence(phase_rate);
            end
            // now and then hold off until the block has drained
            if ($urandom_range(0, 30) == 0) go_idle();
         end
      end

      // Drain, then keep the clock running so any stray result would show before the verdict.
      go_idle();
      repeat (4) @(posedge clock);
      $display("ran %0d items over %0d acceleration settings (0, 1, 3000, 32767 and random),",
               items_sent, rate_writes + 1);
      $display("checked %0d results, %0d mismatching", checked_count, fail_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
